[rtl/lsu_pkg.sv]
// Shared types, operation codes and float conversion functions for the load/store unit.
package lsu_pkg;

	localparam longint unsigned LSU_MEM_BYTES = 64'd65536;

	localparam logic [3:0] OP_LDZ     = 4'd0;
	localparam logic [3:0] OP_LDSEXT  = 4'd1;
	localparam logic [3:0] OP_LDREV   = 4'd2;
	localparam logic [3:0] OP_LDRSV   = 4'd3;
	localparam logic [3:0] OP_ST      = 4'd4;
	localparam logic [3:0] OP_STREV   = 4'd5;
	localparam logic [3:0] OP_STCOND  = 4'd6;
	localparam logic [3:0] OP_LFS     = 4'd7;
	localparam logic [3:0] OP_LFD     = 4'd8;
	localparam logic [3:0] OP_STFS    = 4'd9;
	localparam logic [3:0] OP_STFD    = 4'd10;
	localparam logic [3:0] OP_STFIW   = 4'd11;

	localparam logic [1:0] SZ_DOUBLE = 2'd3;

	typedef struct packed {
		logic [3:0]         operation;
		logic [1:0]         size_code;
		logic               update_form;
		logic [63:0]        base_value;
		logic               base_is_zero;
		logic signed [63:0] offset;
		logic [63:0]        store_value;
		logic               summary_overflow;
	} lsu_in_t;

	typedef struct packed {
		logic [63:0] reg_value;
		logic        reg_write;
		logic [31:0] update_value;
		logic        update_write;
		logic [3:0]  cr0_value;
		logic        cr0_write;
		logic [31:0] mem_address;
	} lsu_out_t;

	// One byte access to the data RAM
	typedef struct packed {
		logic        en;
		logic        we;
		logic [31:0] addr;
		logic [7:0]  wdata;
	} lsu_ram_req_t;

	// Architected double to single bit conversion
	function automatic logic [31:0] double_to_single(input logic [63:0] x);
		logic [10:0] e;
		logic [31:0] t;
		logic [4:0]  sh;
		e = x[62:52];
		if (e > 11'd896 || x[62:0] == 63'd0 || e < 11'd874) begin
			return {x[63:62], x[58:29]};
		end
		sh = 5'(11'd905 - e);
		t = {1'b1, x[51:21]} >> sh;
		t[31] = t[31] | x[63];
		return t;
	endfunction

	// Single to double widening, denormals normalized
	function automatic logic [63:0] single_to_double(input logic [31:0] w);
		logic [7:0]  e;
		logic [22:0] f;
		logic [4:0]  lead;
		logic [4:0]  sh;
		logic [10:0] de;
		logic [22:0] fn;
		e = w[30:23];
		f = w[22:0];
		lead = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (f[i]) lead = 5'(i);
		end
		sh = 5'(5'd23 - lead);
		de = 11'(11'd897 - 11'(sh));
		fn = 23'({f, 1'b0} << (sh - 5'd1));
		if (e == 8'hFF) return {w[31], 11'h7FF, f, 29'd0};
		if (e == 8'd0) begin
			if (f == 23'd0) return {w[31], 63'd0};
			return {w[31], de, fn, 29'd0};
		end
		return {w[31], 11'(11'(e) + 11'd896), f, 29'd0};
	endfunction

	// Byte reversal at the access width
	function automatic logic [63:0] rev_bytes(input logic [63:0] v, input logic [3:0] nb);
		case (nb)
			4'd2:    return {48'd0, v[7:0], v[15:8]};
			4'd4:    return {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]};
			4'd8:    return {v[7:0], v[15:8], v[23:16], v[31:24],
				v[39:32], v[47:40], v[55:48], v[63:56]};
			default: return {56'd0, v[7:0]};
		endcase
	endfunction

endpackage

[rtl/lsu_ram.sv]
// Byte-wide single-port data RAM with registered read data.
module lsu_ram #(
	parameter int AW = 16
) (
	input  logic                 clk,
	input  lsu_pkg::lsu_ram_req_t req,
	output logic [7:0]           rdata
);
	import lsu_pkg::*;

	logic [7:0] mem [0:(64'd1 << AW) - 1];

	// One read or one write per cycle
	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr[AW-1:0]] <= req.wdata;
			end else begin
				rdata <= mem[req.addr[AW-1:0]];
			end
		end
	end
endmodule

[rtl/load_store_unit_with_reservation.sv]
// Load/store unit: sequencer over a byte RAM, reservation registers, result register.
// Items with no memory access go straight to the result state; loads and stores move
// their bytes through the single byte port of the RAM, one byte per cycle.
// Throughput: one item at a time; the next item is taken once the result is queued.
// Reset clears the sequencer, reservations and result valid; RAM contents are undefined.
// MEM_BYTES is a power of two; byte addresses wrap modulo MEM_BYTES.
module load_store_unit_with_reservation #(
	parameter longint unsigned MEM_BYTES = lsu_pkg::LSU_MEM_BYTES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lsu_pkg::lsu_in_t in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output lsu_pkg::lsu_out_t out_item
);
	import lsu_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_XFER = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t       state_q;
	logic [3:0]   op_q;
	logic [3:0]   nb_q;
	logic [3:0]   cnt_q;
	logic [3:0]   got_q;
	logic         rd_s1;
	logic         is_wr_q;
	logic [AW-1:0] addr_q;
	logic [63:0]  wdata_q;
	logic [63:0]  acc_q;
	logic [31:0]  ea_q;
	logic         upd_q;
	logic [3:0]   cr_q;
	logic         cw_q;
	logic         w_rsv_v_q;
	logic [31:0]  w_rsv_a_q;
	logic         d_rsv_v_q;
	logic [31:0]  d_rsv_a_q;
	logic         out_valid_q;
	lsu_out_t     out_q;

	lsu_ram_req_t ram_req;
	logic [7:0]   ram_rdata;

	logic         accept;
	logic [31:0]  ea;
	logic [3:0]   nb_in;
	logic [3:0]   nb_sz;
	logic         is_load;
	logic         is_store;
	logic         sc_ok;
	logic [63:0]  st_val;
	logic [63:0]  ld_val;
	logic         done_fire;

	lsu_ram #(.AW(AW)) u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign done_fire = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Decode of the incoming item
	always_comb begin
		ea = 32'((in_item.base_is_zero ? 64'd0 : in_item.base_value) + in_item.offset);
		nb_sz = 4'd1 << in_item.size_code;
		is_load = (in_item.operation <= OP_LDRSV) || (in_item.operation == OP_LFS)
			|| (in_item.operation == OP_LFD);
		is_store = (in_item.operation == OP_ST) || (in_item.operation == OP_STREV)
			|| (in_item.operation == OP_STFS) || (in_item.operation == OP_STFD)
			|| (in_item.operation == OP_STFIW);
		if (in_item.size_code == SZ_DOUBLE) sc_ok = d_rsv_v_q && (d_rsv_a_q == ea);
		else sc_ok = w_rsv_v_q && (w_rsv_a_q == ea);
		nb_in = nb_sz;
		st_val = in_item.store_value;
		case (in_item.operation)
			OP_LFS, OP_STFIW: nb_in = 4'd4;
			OP_LFD, OP_STFD:  nb_in = 4'd8;
			OP_STFS: begin
				nb_in = 4'd4;
				st_val = {32'd0, double_to_single(in_item.store_value)};
			end
			OP_STREV: st_val = rev_bytes(in_item.store_value, nb_sz);
			default: ;
		endcase
	end

	// RAM port: writes stream from the top of wdata_q, reads issue ahead of capture
	always_comb begin
		ram_req.en    = (state_q == ST_XFER) && (is_wr_q || (cnt_q < nb_q));
		ram_req.we    = is_wr_q;
		ram_req.addr  = 32'(addr_q);
		ram_req.wdata = wdata_q[63:56];
	end

	// Load result formatting
	always_comb begin
		case (op_q)
			OP_LDSEXT: begin
				case (nb_q)
					4'd1:    ld_val = {{56{acc_q[7]}}, acc_q[7:0]};
					4'd2:    ld_val = {{48{acc_q[15]}}, acc_q[15:0]};
					4'd4:    ld_val = {{32{acc_q[31]}}, acc_q[31:0]};
					default: ld_val = acc_q;
				endcase
			end
			OP_LDREV: ld_val = rev_bytes(acc_q, nb_q);
			OP_LFS:   ld_val = single_to_double(acc_q[31:0]);
			default:  ld_val = acc_q;
		endcase
	end

	// Result register
	always_ff @(posedge clk) begin
		if (done_fire) begin
			out_q.reg_value    <= (op_q <= OP_LDRSV || op_q == OP_LFS || op_q == OP_LFD)
				? ld_val : 64'd0;
			out_q.reg_write    <= (op_q <= OP_LDRSV || op_q == OP_LFS || op_q == OP_LFD);
			out_q.update_value <= ea_q;
			out_q.update_write <= upd_q;
			out_q.cr0_value    <= cr_q;
			out_q.cr0_write    <= cw_q;
			out_q.mem_address  <= ea_q;
		end
	end

	// Item context and byte datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= in_item.operation;
			nb_q    <= nb_in;
			cnt_q   <= 4'd0;
			got_q   <= 4'd0;
			is_wr_q <= !is_load;
			addr_q  <= ea[AW-1:0];
			wdata_q <= st_val << (7'd8 * 7'(4'd8 - nb_in));
			acc_q   <= 64'd0;
			ea_q    <= ea;
			upd_q   <= in_item.update_form && (in_item.operation <= OP_STFIW);
			cw_q    <= (in_item.operation == OP_STCOND);
			cr_q    <= (in_item.operation == OP_STCOND)
				? {2'b00, sc_ok, in_item.summary_overflow} : 4'd0;
		end else if (state_q == ST_XFER) begin
			if (ram_req.en) begin
				addr_q  <= addr_q + AW'(1);
				cnt_q   <= cnt_q + 4'd1;
				wdata_q <= {wdata_q[55:0], 8'd0};
			end
			if (rd_s1) begin
				acc_q <= {acc_q[55:0], ram_rdata};
				got_q <= got_q + 4'd1;
			end
		end
	end

	// Sequencer, reservations and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_s1       <= 1'b0;
			w_rsv_v_q   <= 1'b0;
			w_rsv_a_q   <= 32'd0;
			d_rsv_v_q   <= 1'b0;
			d_rsv_a_q   <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= ram_req.en && !ram_req.we;
			if (done_fire) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_load || is_store
							|| (in_item.operation == OP_STCOND && sc_ok)) begin
							state_q <= ST_XFER;
						end else begin
							state_q <= ST_DONE;
						end
						if (in_item.operation == OP_LDRSV) begin
							if (in_item.size_code == SZ_DOUBLE) begin
								d_rsv_v_q <= 1'b1;
								d_rsv_a_q <= ea;
							end else begin
								w_rsv_v_q <= 1'b1;
								w_rsv_a_q <= ea;
							end
						end
						if (in_item.operation == OP_STCOND && sc_ok) begin
							if (in_item.size_code == SZ_DOUBLE) d_rsv_v_q <= 1'b0;
							else w_rsv_v_q <= 1'b0;
						end
					end
				end
				ST_XFER: begin
					if (is_wr_q) begin
						if (cnt_q == nb_q - 4'd1) state_q <= ST_DONE;
					end else if (rd_s1 && got_q == nb_q - 4'd1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[rtl/lsu_checker.sv]
// Port-level checks for the load/store unit, bound to the top level.
module lsu_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input lsu_pkg::lsu_out_t out_item
);
	import lsu_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	// One item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item taken while busy");

	// Both address fields carry the effective address
	a_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.update_value == out_item.mem_address)
		else $error("address fields differ");

	// CR0 only for conditional stores, never with a register load
	a_cr0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.cr0_write |-> out_item.cr0_value == 4'd0)
		else $error("CR0 value without CR0 write");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.reg_write && out_item.cr0_write))
		else $error("load and conditional store at once");
endmodule

bind load_store_unit_with_reservation lsu_checker u_lsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

[bench/load_store_unit_with_reservation_tb.sv]
// Self-checking bench for the load/store unit: queued stimulus, clocked driver, monitor, predictor.
module load_store_unit_with_reservation_tb;
	import lsu_pkg::*;

	localparam int          MEM_SIZE    = 65536;
	localparam int          CYCLE_LIMIT = 1000000;
	localparam int          RAND_ITEMS  = 1900;
	localparam logic [3:0]  OP_NONE_LO  = 4'd12;
	localparam logic [3:0]  OP_NONE_HI  = 4'd15;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	lsu_in_t   in_item = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	lsu_out_t  out_item;

	load_store_unit_with_reservation dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	always #5 clk = ~clk;

	// Stimulus and expectation stores
	lsu_in_t  access_q[$];
	lsu_out_t result_q[$];
	int       errors = 0;
	int       sent = 0;
	int       cycles = 0;
	bit       gen_done = 0;
	bit       item_done = 0;
	bit       paused_once = 0;
	bit       holding = 0;

	// Predictor state
	logic [7:0]  mem_img [0:MEM_SIZE-1];
	bit          wres_v = 0, dres_v = 0;
	logic [31:0] wres_a = '0, dres_a = '0;

	// Generator bookkeeping: bytes known written, start addresses of stores
	bit          written [0:MEM_SIZE-1];
	int unsigned store_ea[$];
	int          store_nb[$];

	function automatic logic [63:0] mem_read(logic [31:0] ea, int nb);
		logic [63:0] v;
		v = '0;
		for (int i = 0; i < nb; i++)
			v = {v[55:0], mem_img[(ea + 32'(i)) % MEM_SIZE]};
		return v;
	endfunction

	function automatic void mem_write(logic [31:0] ea, int nb, logic [63:0] v);
		for (int i = 0; i < nb; i++)
			mem_img[(ea + 32'(i)) % MEM_SIZE] = v[8*(nb-1-i) +: 8];
	endfunction

	function automatic logic [63:0] swap_bytes(logic [63:0] v, int nb);
		logic [63:0] r;
		r = '0;
		for (int i = 0; i < nb; i++)
			r[8*(nb-1-i) +: 8] = v[8*i +: 8];
		return r;
	endfunction

	function automatic logic [63:0] sext(logic [63:0] v, int nb);
		logic [63:0] r;
		if (nb == 8) return v;
		r = v;
		for (int i = 8*nb; i < 64; i++) r[i] = v[8*nb-1];
		return r;
	endfunction

	// Double to single store conversion, denormal range shifted in
	function automatic logic [31:0] narrow_float(logic [63:0] x);
		logic [10:0] e;
		logic [31:0] t;
		e = x[62:52];
		if (e > 11'd896 || x[62:0] == 63'd0 || e < 11'd874)
			return {x[63:62], x[58:29]};
		t = {1'b1, x[51:21]} >> (11'd905 - e);
		t[31] = t[31] | x[63];
		return t;
	endfunction

	// Single to double widening, denormals normalized
	function automatic logic [63:0] widen_float(logic [31:0] w);
		logic [7:0]  e;
		logic [23:0] f;
		logic [10:0] de;
		e = w[30:23];
		f = {1'b0, w[22:0]};
		if (e == 8'hFF) return {w[31], 11'h7FF, f[22:0], 29'd0};
		if (e == 8'd0) begin
			if (f == 24'd0) return {w[31], 63'd0};
			de = 11'd897;
			while (!f[23]) begin
				f = f << 1;
				de = de - 11'd1;
			end
			return {w[31], de, f[22:0], 29'd0};
		end
		return {w[31], 11'(e) + 11'd896, f[22:0], 29'd0};
	endfunction

	// Executes one access on the shadow state and returns its expected result
	function automatic lsu_out_t execute_access(lsu_in_t it);
		lsu_out_t    r;
		logic [31:0] ea;
		int          nb;
		bit          hit;
		r = '0;
		nb = 1 << it.size_code;
		ea = 32'((it.base_is_zero ? 64'd0 : it.base_value) + it.offset);
		r.update_value = ea;
		r.mem_address = ea;
		if (it.operation <= OP_STFIW) r.update_write = it.update_form;
		case (it.operation)
			OP_LDZ: begin
				r.reg_value = mem_read(ea, nb); r.reg_write = 1;
			end
			OP_LDSEXT: begin
				r.reg_value = sext(mem_read(ea, nb), nb); r.reg_write = 1;
			end
			OP_LDREV: begin
				r.reg_value = swap_bytes(mem_read(ea, nb), nb); r.reg_write = 1;
			end
			OP_LDRSV: begin
				r.reg_value = mem_read(ea, nb); r.reg_write = 1;
				if (nb == 8) begin
					dres_v = 1; dres_a = ea;
				end else begin
					wres_v = 1; wres_a = ea;
				end
			end
			OP_ST:    mem_write(ea, nb, it.store_value);
			OP_STREV: mem_write(ea, nb, swap_bytes(it.store_value, nb));
			OP_STCOND: begin
				r.cr0_write = 1;
				hit = (nb == 8) ? (dres_v && dres_a == ea) : (wres_v && wres_a == ea);
				if (hit) begin
					mem_write(ea, nb, it.store_value);
					if (nb == 8) dres_v = 0;
					else wres_v = 0;
					r.cr0_value = {2'b00, 1'b1, it.summary_overflow};
				end else begin
					r.cr0_value = {3'b000, it.summary_overflow};
				end
			end
			OP_LFS: begin
				r.reg_value = widen_float(mem_read(ea, 4)); r.reg_write = 1;
			end
			OP_LFD: begin
				r.reg_value = mem_read(ea, 8); r.reg_write = 1;
			end
			OP_STFS:  mem_write(ea, 4, {32'd0, narrow_float(it.store_value)});
			OP_STFD:  mem_write(ea, 8, it.store_value);
			OP_STFIW: mem_write(ea, 4, {32'd0, it.store_value[31:0]});
			default: ;
		endcase
		return r;
	endfunction

	function automatic int access_bytes(logic [3:0] op, logic [1:0] sz);
		if (op == OP_LFS || op == OP_STFS || op == OP_STFIW) return 4;
		if (op == OP_LFD || op == OP_STFD) return 8;
		return 1 << sz;
	endfunction

	function automatic bit all_written(logic [31:0] ea, int nb);
		for (int i = 0; i < nb; i++)
			if (!written[(ea + 32'(i)) % MEM_SIZE]) return 0;
		return 1;
	endfunction

	// Queue one item; the address is split randomly over base and offset
	task automatic add_item(logic [3:0] op, logic [1:0] sz, logic [31:0] ea,
			logic [63:0] sv);
		lsu_in_t it;
		int      nb;
		it.operation = op;
		it.size_code = sz;
		it.update_form = 1'($urandom_range(0, 1));
		it.base_is_zero = ($urandom_range(0, 3) == 0);
		it.base_value = {$urandom, $urandom};
		it.store_value = sv;
		it.summary_overflow = 1'($urandom_range(0, 1));
		if (it.base_is_zero) it.offset = {$urandom, ea};
		else it.offset = {$urandom, ea} - it.base_value;
		nb = access_bytes(op, sz);
		if (op == OP_ST || op == OP_STREV || op == OP_STFS || op == OP_STFD
				|| op == OP_STFIW) begin
			for (int i = 0; i < nb; i++) written[(ea + 32'(i)) % MEM_SIZE] = 1;
			store_ea.push_back(ea);
			store_nb.push_back(nb);
		end
		access_q.push_back(it);
	endtask

	function automatic logic [31:0] rand_ea();
		if ($urandom_range(0, 3) == 0) return $urandom;
		return $urandom_range(0, 511);
	endfunction

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Load from a known-written location; falls back to one byte
	task automatic add_load(logic [3:0] op);
		int          k;
		logic [31:0] ea;
		logic [1:0]  sz;
		k = $urandom_range(0, store_ea.size() - 1);
		ea = store_ea[k];
		sz = 2'($urandom_range(0, $clog2(store_nb[k])));
		if (!all_written(ea, access_bytes(op, sz))) begin
			op = OP_LDZ; sz = 2'd0;
		end
		add_item(op, sz, ea, rand_word());
	endtask

	task automatic add_stfs_value(logic [31:0] ea);
		logic [63:0] x;
		x = rand_word();
		if ($urandom_range(0, 1)) x[62:52] = 11'($urandom_range(860, 910));
		add_item(OP_STFS, 2'($urandom), ea, x);
	endtask

	// Directed cases, then random stream
	initial begin : stimulus
		logic [31:0] ea;
		logic [3:0]  op;
		logic [1:0]  sz;
		int          r;
		foreach (written[i]) written[i] = 0;
		add_item(OP_ST, 2'd3, 32'h10, 64'h8081_8283_8485_8687);
		add_item(OP_LDZ, 2'd3, 32'h10, '0);
		add_item(OP_LDSEXT, 2'd0, 32'h10, '0);
		add_item(OP_LDSEXT, 2'd1, 32'h10, '0);
		add_item(OP_LDSEXT, 2'd2, 32'h10, '0);
		add_item(OP_LDSEXT, 2'd3, 32'h10, '0);
		add_item(OP_LDREV, 2'd0, 32'h10, '0);
		add_item(OP_LDREV, 2'd3, 32'h10, '0);
		add_item(OP_STREV, 2'd2, 32'h20, 64'hFFFF_FFFF_0102_0304);
		add_item(OP_LDZ, 2'd2, 32'h20, '0);
		add_item(OP_ST, 2'd3, 32'hFFFF_FFFC, 64'hFFFF_FFFF_FFFF_FFFF);
		add_item(OP_LFD, 2'd0, 32'hFFFF_FFFC, '0);
		add_item(OP_STFIW, 2'd0, 32'h30, 64'h1);
		add_item(OP_LFS, 2'd0, 32'h30, '0);
		add_item(OP_STFIW, 2'd0, 32'h34, 64'h7F80_0001);
		add_item(OP_LFS, 2'd0, 32'h34, '0);
		add_item(OP_STFS, 2'd0, 32'h38, 64'h3700_0000_0000_0000);
		add_item(OP_STFS, 2'd0, 32'h3C, 64'h8000_0000_0000_0000);
		add_item(OP_LFS, 2'd0, 32'h38, '0);
		add_item(OP_STFD, 2'd0, 32'h40, 64'h0);
		add_item(OP_LDRSV, 2'd2, 32'h40, '0);
		add_item(OP_STCOND, 2'd2, 32'h40, 64'hDEAD_BEEF);
		add_item(OP_STCOND, 2'd2, 32'h40, 64'h1234_5678);
		add_item(OP_LDRSV, 2'd3, 32'h40, '0);
		add_item(OP_STCOND, 2'd3, 32'h40, rand_word());
		add_item(OP_NONE_LO, 2'd3, 32'h0, rand_word());
		add_item(OP_NONE_HI, 2'd0, 32'hFFFF_FFFF, rand_word());
		for (int n = 0; n < RAND_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				case ($urandom_range(0, 4))
					0: op = OP_ST;
					1: op = OP_STREV;
					2: op = OP_STFS;
					3: op = OP_STFD;
					default: op = OP_STFIW;
				endcase
				ea = rand_ea();
				if (op == OP_STFS) add_stfs_value(ea);
				else add_item(op, 2'($urandom), ea, rand_word());
			end else if (r < 60) begin
				case ($urandom_range(0, 4))
					0: op = OP_LDZ;
					1: op = OP_LDSEXT;
					2: op = OP_LDREV;
					3: op = OP_LFS;
					default: op = OP_LFD;
				endcase
				add_load(op);
			end else if (r < 82) begin
				// Reserve, maybe something in between, then conditional store
				ea = rand_ea();
				sz = 2'($urandom);
				add_item(OP_ST, 2'd3, ea, rand_word());
				add_item(OP_LDRSV, sz, ea, '0);
				if ($urandom_range(0, 2) == 0) add_load(OP_LDZ);
				if ($urandom_range(0, 6) != 0)
					add_item(OP_STCOND, sz, ea, rand_word());
				else
					add_item(OP_STCOND, 2'($urandom), ea + 32'($urandom_range(0, 8)),
						rand_word());
				n += 2;
			end else if (r < 95) begin
				add_item(OP_STCOND, 2'($urandom), rand_ea(), rand_word());
			end else begin
				add_item(4'($urandom_range(12, 15)), 2'($urandom), $urandom, rand_word());
			end
		end
		gen_done = 1;
	end

	// Per-phase idle percentages
	function automatic int send_idle();
		case ((sent / 150) % 4)
			1: return 66;
			3: return 20;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_idle();
		case ((sent / 150) % 4)
			2: return 66;
			3: return 20;
			default: return 0;
		endcase
	endfunction

	// Reset release
	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	// Acceptance: predict at the edge that takes the item
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			result_q.push_back(execute_access(in_item));
			sent++;
			item_done = 1;
		end
	end

	// Driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || item_done)) begin
			item_done = 0;
			if (sent == 1000 && !paused_once) begin
				holding = 1;
				paused_once = 1;
			end
			if (holding && result_q.size() == 0) holding = 0;
			if (!holding && access_q.size() > 0 && $urandom_range(1, 100) > send_idle()) begin
				in_valid <= 1'b1;
				in_item <= access_q.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stalls
	always @(negedge clk) begin
		out_ready <= arst_n && ($urandom_range(1, 100) > recv_idle());
	end

	// Monitor
	always @(posedge clk) begin
		lsu_out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				$error("result with no pending expectation");
				errors++;
			end else begin
				e = result_q.pop_front();
				if (out_item.reg_value !== e.reg_value) begin
					$error("reg_value exp %h got %h", e.reg_value, out_item.reg_value);
					errors++;
				end
				if (out_item.reg_write !== e.reg_write) begin
					$error("reg_write exp %b got %b", e.reg_write, out_item.reg_write);
					errors++;
				end
				if (out_item.update_value !== e.update_value) begin
					$error("update_value exp %h got %h", e.update_value, out_item.update_value);
					errors++;
				end
				if (out_item.update_write !== e.update_write) begin
					$error("update_write exp %b got %b", e.update_write, out_item.update_write);
					errors++;
				end
				if (out_item.cr0_value !== e.cr0_value) begin
					$error("cr0_value exp %h got %h", e.cr0_value, out_item.cr0_value);
					errors++;
				end
				if (out_item.cr0_write !== e.cr0_write) begin
					$error("cr0_write exp %b got %b", e.cr0_write, out_item.cr0_write);
					errors++;
				end
				if (out_item.mem_address !== e.mem_address) begin
					$error("mem_address exp %h got %h", e.mem_address, out_item.mem_address);
					errors++;
				end
			end
		end
	end

	// Timeout
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// End of run
	initial begin
		wait (gen_done);
		@(posedge clk);
		while (access_q.size() > 0 || in_valid || result_q.size() > 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (errors == 0 && result_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
